### src/pvc_pkg.sv
// Package for the proportional velocity command block.
// Holds the fixed-point format, derived widths, pipeline depths, reset values and
// register indexes shared by all modules. No dependencies.
package pvc_pkg;

    localparam int FRAC_BITS = 16;

    // Pi and 2*pi from a Q30 value, rounded to nearest at FRAC_BITS.
    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic signed [31:0] PI_Q =
        32'((PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    localparam logic signed [31:0] TWO_PI_Q =
        32'((64'd2 * PI_Q30 + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));

    localparam int XW   = 32;                 // position width
    localparam int HW   = 19;                 // input heading width
    localparam int LW   = 31;                 // limit and time step width
    localparam int DXW  = XW + 1;             // position error width
    localparam int AW   = DXW + 32 - FRAC_BITS; // velocity magnitude before limiting
    localparam int TMW  = 64 - FRAC_BITS;     // turn rate magnitude before clamping
    localparam int KW   = $clog2(AW);         // normalizing shift count width
    localparam int SQW  = 2 * LW;             // square of a normalized component
    localparam int NW   = 64;                 // radicand, padded to an even width
    localparam int RTW  = NW / 2;             // root width
    localparam int REMW = RTW + 2;            // root remainder width
    localparam int DW   = 2 * LW;             // dividend width
    localparam int QW   = LW;                 // quotient width
    localparam int PW   = 32 + LW - FRAC_BITS; // step product magnitude width

    localparam int FRONT_STAGES = 5;
    localparam int SQ_STAGES    = RTW;
    localparam int DIV_STAGES   = QW;
    localparam int BACK_STAGES  = 3;
    localparam int LATENCY = FRONT_STAGES + SQ_STAGES + DIV_STAGES + BACK_STAGES;

    localparam logic [31:0] RST_TRANS_GAIN = 32'd262144;
    localparam logic [31:0] RST_ROT_GAIN   = 32'd65536;
    localparam logic [30:0] RST_SPEED_LIM  = 31'd196608;
    localparam logic [30:0] RST_TURN_LIM   = 31'd11796480;
    localparam logic [30:0] RST_TIME_STEP  = 31'd1245;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANS_GAIN = 3'd0,
        CFG_ROT_GAIN   = 3'd1,
        CFG_SPEED_LIM  = 3'd2,
        CFG_TURN_LIM   = 3'd3,
        CFG_TIME_STEP  = 3'd4
    } t_cfg_idx;

    // Per-item data that bypasses the square root and divider.
    typedef struct packed {
        logic signed [XW-1:0] sx;
        logic signed [XW-1:0] sy;
        logic signed [HW-1:0] sh;
        logic                 sgx;
        logic                 sgy;
        logic signed [31:0]   vx;
        logic signed [31:0]   vy;
        logic signed [31:0]   vt;
        logic                 over;
    } t_side;

endpackage

### src/pvc_front.sv
// Front end: errors, heading wrap, gain products, turn clamp, normalization,
// squares, speed test and dividends over five register stages.
// Depends on pvc_pkg.
module pvc_front (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [pvc_pkg::XW-1:0] i_start_x,
    input  logic signed [pvc_pkg::XW-1:0] i_start_y,
    input  logic signed [pvc_pkg::HW-1:0] i_start_heading,
    input  logic signed [pvc_pkg::XW-1:0] i_goal_x,
    input  logic signed [pvc_pkg::XW-1:0] i_goal_y,
    input  logic signed [pvc_pkg::HW-1:0] i_goal_heading,
    input  logic [31:0]                   i_trans_gain,
    input  logic [31:0]                   i_rot_gain,
    input  logic [pvc_pkg::LW-1:0]        i_speed_lim,
    input  logic [pvc_pkg::LW-1:0]        i_turn_lim,
    output logic [pvc_pkg::NW-1:0]        o_n,
    output logic [pvc_pkg::DW-1:0]        o_dvx,
    output logic [pvc_pkg::DW-1:0]        o_dvy,
    output pvc_pkg::t_side                o_side
);
    import pvc_pkg::*;

    // Stage 1
    logic signed [DXW-1:0] r1_dx, r1_dy;
    logic signed [31:0]    r1_dth;
    logic signed [XW-1:0]  r1_sx, r1_sy;
    logic signed [HW-1:0]  r1_sh;
    // Stage 2
    logic [AW-1:0]         r2_ax, r2_ay;
    logic [TMW-1:0]        r2_tm;
    logic                  r2_sgx, r2_sgy, r2_sgt;
    logic signed [XW-1:0]  r2_sx, r2_sy;
    logic signed [HW-1:0]  r2_sh;
    // Stage 3
    logic [LW-1:0]         r3_nx, r3_ny;
    logic                  r3_big;
    logic signed [31:0]    r3_vx, r3_vy, r3_vt;
    logic                  r3_sgx, r3_sgy;
    logic signed [XW-1:0]  r3_sx, r3_sy;
    logic signed [HW-1:0]  r3_sh;
    // Stage 4
    logic [SQW-1:0]        r4_sqx, r4_sqy, r4_lim2;
    logic [DW-1:0]         r4_dvx, r4_dvy;
    logic                  r4_big;
    logic signed [31:0]    r4_vx, r4_vy, r4_vt;
    logic                  r4_sgx, r4_sgy;
    logic signed [XW-1:0]  r4_sx, r4_sy;
    logic signed [HW-1:0]  r4_sh;
    // Stage 5
    logic [NW-1:0]         r5_n;
    logic [DW-1:0]         r5_dvx, r5_dvy;
    t_side                 r5_side;

    logic signed [31:0]    n_dth;
    logic [DXW-1:0]        n_mx, n_my;
    logic [31:0]           n_mt;
    logic [DXW+31:0]       n_px, n_py;
    logic [63:0]           n_pt;
    logic [AW-1:0]         n_or;
    logic [KW-1:0]         n_k;
    logic [AW-1:0]         n_shx, n_shy;
    logic [LW-1:0]         n_tc;
    logic [SQW:0]          n_sum;

    // Heading error wrapped once toward [-pi, pi].
    always_comb begin
        n_dth = 32'(i_goal_heading) - 32'(i_start_heading);
        if (n_dth < -PI_Q) begin
            n_dth = n_dth + TWO_PI_Q;
        end
        if (n_dth > PI_Q) begin
            n_dth = n_dth - TWO_PI_Q;
        end
    end

    always_comb begin
        n_mx = r1_dx[DXW-1] ? DXW'(-r1_dx) : DXW'(r1_dx);
        n_my = r1_dy[DXW-1] ? DXW'(-r1_dy) : DXW'(r1_dy);
        n_mt = r1_dth[31] ? 32'(-r1_dth) : 32'(r1_dth);
        n_px = n_mx * i_trans_gain;
        n_py = n_my * i_trans_gain;
        n_pt = n_mt * i_rot_gain;
    end

    // Shift both components right together until each is below 2^31.
    always_comb begin
        n_or = r2_ax | r2_ay;
        n_k  = '0;
        for (int i = LW; i < AW; i++) begin
            if (n_or[i]) begin
                n_k = KW'(i - LW + 1);
            end
        end
        n_shx = r2_ax >> n_k;
        n_shy = r2_ay >> n_k;
        n_tc  = (r2_tm > TMW'(i_turn_lim)) ? i_turn_lim : r2_tm[LW-1:0];
    end

    assign n_sum = {1'b0, r4_sqx} + {1'b0, r4_sqy};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_dx  <= {i_goal_x[XW-1], i_goal_x} - {i_start_x[XW-1], i_start_x};
            r1_dy  <= {i_goal_y[XW-1], i_goal_y} - {i_start_y[XW-1], i_start_y};
            r1_dth <= n_dth;
            r1_sx  <= i_start_x;
            r1_sy  <= i_start_y;
            r1_sh  <= i_start_heading;

            r2_ax  <= n_px[DXW+31:FRAC_BITS];
            r2_ay  <= n_py[DXW+31:FRAC_BITS];
            r2_tm  <= n_pt[63:FRAC_BITS];
            r2_sgx <= r1_dx[DXW-1];
            r2_sgy <= r1_dy[DXW-1];
            r2_sgt <= r1_dth[31];
            r2_sx  <= r1_sx;
            r2_sy  <= r1_sy;
            r2_sh  <= r1_sh;

            r3_nx  <= n_shx[LW-1:0];
            r3_ny  <= n_shy[LW-1:0];
            r3_big <= (n_k != '0);
            r3_vx  <= r2_sgx ? -{1'b0, r2_ax[LW-1:0]} : {1'b0, r2_ax[LW-1:0]};
            r3_vy  <= r2_sgy ? -{1'b0, r2_ay[LW-1:0]} : {1'b0, r2_ay[LW-1:0]};
            r3_vt  <= r2_sgt ? -{1'b0, n_tc} : {1'b0, n_tc};
            r3_sgx <= r2_sgx;
            r3_sgy <= r2_sgy;
            r3_sx  <= r2_sx;
            r3_sy  <= r2_sy;
            r3_sh  <= r2_sh;

            r4_sqx  <= r3_nx * r3_nx;
            r4_sqy  <= r3_ny * r3_ny;
            r4_lim2 <= i_speed_lim * i_speed_lim;
            r4_dvx  <= r3_nx * i_speed_lim;
            r4_dvy  <= r3_ny * i_speed_lim;
            r4_big  <= r3_big;
            r4_vx   <= r3_vx;
            r4_vy   <= r3_vy;
            r4_vt   <= r3_vt;
            r4_sgx  <= r3_sgx;
            r4_sgy  <= r3_sgy;
            r4_sx   <= r3_sx;
            r4_sy   <= r3_sy;
            r4_sh   <= r3_sh;

            r5_n         <= NW'(n_sum);
            r5_dvx       <= r4_dvx;
            r5_dvy       <= r4_dvy;
            r5_side.sx   <= r4_sx;
            r5_side.sy   <= r4_sy;
            r5_side.sh   <= r4_sh;
            r5_side.sgx  <= r4_sgx;
            r5_side.sgy  <= r4_sgy;
            r5_side.vx   <= r4_vx;
            r5_side.vy   <= r4_vy;
            r5_side.vt   <= r4_vt;
            r5_side.over <= r4_big || (n_sum > {1'b0, r4_lim2});
        end
    end

    assign o_n    = r5_n;
    assign o_dvx  = r5_dvx;
    assign o_dvy  = r5_dvy;
    assign o_side = r5_side;

endmodule

### src/pvc_isqrt.sv
// Pipelined integer square root, one root bit per register stage.
// Depends on pvc_pkg.
module pvc_isqrt (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [pvc_pkg::NW-1:0]  i_n,
    output logic [pvc_pkg::RTW-1:0] o_root
);
    import pvc_pkg::*;

    typedef struct packed {
        logic [REMW-1:0] rem;
        logic [RTW-1:0]  root;
    } t_sq_step;

    logic [REMW-1:0] r_rem  [SQ_STAGES];
    logic [RTW-1:0]  r_root [SQ_STAGES];
    logic [NW-1:0]   r_n    [SQ_STAGES];

    function automatic t_sq_step sq_step(input logic [REMW-1:0] rem,
                                         input logic [RTW-1:0] root,
                                         input logic [1:0] pair);
        logic [REMW+1:0] cur;
        logic [REMW+1:0] trial;
        t_sq_step        res;
        cur   = {rem, pair};
        trial = (REMW+2)'({root, 2'b01});
        if (cur >= trial) begin
            res.rem  = REMW'(cur - trial);
            res.root = {root[RTW-2:0], 1'b1};
        end else begin
            res.rem  = REMW'(cur);
            res.root = {root[RTW-2:0], 1'b0};
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        t_sq_step s;
        if (i_en) begin
            s = sq_step('0, '0, i_n[NW-1 -: 2]);
            r_rem[0]  <= s.rem;
            r_root[0] <= s.root;
            r_n[0]    <= i_n;
            for (int j = 1; j < SQ_STAGES; j++) begin
                s = sq_step(r_rem[j-1], r_root[j-1], r_n[j-1][NW-1-2*j -: 2]);
                r_rem[j]  <= s.rem;
                r_root[j] <= s.root;
                r_n[j]    <= r_n[j-1];
            end
        end
    end

    assign o_root = r_root[SQ_STAGES-1];

endmodule

### src/pvc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// The quotient is known to fit in QW bits. Depends on pvc_pkg.
module pvc_div (
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic [pvc_pkg::DW-1:0]  i_dividend,
    input  logic [pvc_pkg::RTW-1:0] i_divisor,
    output logic [pvc_pkg::QW-1:0]  o_quot
);
    import pvc_pkg::*;

    logic [RTW-1:0] r_rem [DIV_STAGES];
    logic [RTW-1:0] r_dsr [DIV_STAGES];
    logic [DW-1:0]  r_dvd [DIV_STAGES];
    logic [QW-1:0]  r_q   [DIV_STAGES];

    logic [RTW-1:0] n_dsr;

    // A zero root only comes with a zero dividend; divide by one then.
    assign n_dsr = (i_divisor == '0) ? RTW'(1) : i_divisor;

    always_ff @(posedge i_clk) begin
        logic [RTW:0] t;
        if (i_en) begin
            t = {RTW'(i_dividend[DW-1:QW]), i_dividend[QW-1]};
            if (t >= {1'b0, n_dsr}) begin
                r_rem[0] <= RTW'(t - {1'b0, n_dsr});
                r_q[0]   <= QW'(1);
            end else begin
                r_rem[0] <= RTW'(t);
                r_q[0]   <= '0;
            end
            r_dsr[0] <= n_dsr;
            r_dvd[0] <= i_dividend;
            for (int j = 1; j < DIV_STAGES; j++) begin
                t = {r_rem[j-1], r_dvd[j-1][QW-1-j]};
                if (t >= {1'b0, r_dsr[j-1]}) begin
                    r_rem[j] <= RTW'(t - {1'b0, r_dsr[j-1]});
                    r_q[j]   <= {r_q[j-1][QW-2:0], 1'b1};
                end else begin
                    r_rem[j] <= RTW'(t);
                    r_q[j]   <= {r_q[j-1][QW-2:0], 1'b0};
                end
                r_dsr[j] <= r_dsr[j-1];
                r_dvd[j] <= r_dvd[j-1];
            end
        end
    end

    assign o_quot = r_q[DIV_STAGES-1];

endmodule

### src/pvc_back.sv
// Back end: command selection, time-step products and saturating pose update
// over three register stages; the last stage is the output register. Depends on pvc_pkg.
module pvc_back (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  pvc_pkg::t_side         i_side,
    input  logic [pvc_pkg::QW-1:0] i_qx,
    input  logic [pvc_pkg::QW-1:0] i_qy,
    input  logic [pvc_pkg::LW-1:0] i_time_step,
    output logic signed [31:0]     o_cmd_vel_x,
    output logic signed [31:0]     o_cmd_vel_y,
    output logic signed [31:0]     o_cmd_turn_rate,
    output logic signed [31:0]     o_next_x,
    output logic signed [31:0]     o_next_y,
    output logic signed [31:0]     o_next_heading,
    output logic                   o_speed_limited
);
    import pvc_pkg::*;

    logic signed [31:0]   r1_vx, r1_vy, r1_vt;
    logic signed [XW-1:0] r1_sx, r1_sy;
    logic signed [HW-1:0] r1_sh;
    logic                 r1_over;

    logic signed [31:0]   r2_vx, r2_vy, r2_vt;
    logic [PW-1:0]        r2_px, r2_py, r2_pt;
    logic signed [XW-1:0] r2_sx, r2_sy;
    logic signed [HW-1:0] r2_sh;
    logic                 r2_over;

    logic signed [31:0]   r3_vx, r3_vy, r3_vt, r3_nx, r3_ny, r3_nh;
    logic                 r3_over;

    logic [31:0]          n_mx, n_my, n_mt;
    logic [31+LW:0]       n_px, n_py, n_pt;

    always_comb begin
        n_mx = r1_vx[31] ? 32'(-r1_vx) : 32'(r1_vx);
        n_my = r1_vy[31] ? 32'(-r1_vy) : 32'(r1_vy);
        n_mt = r1_vt[31] ? 32'(-r1_vt) : 32'(r1_vt);
        n_px = n_mx * i_time_step;
        n_py = n_my * i_time_step;
        n_pt = n_mt * i_time_step;
    end

    function automatic logic signed [31:0] step_sat(input logic signed [31:0] base,
                                                    input logic neg,
                                                    input logic [PW-1:0] p);
        logic signed [PW+1:0] d;
        logic signed [PW+1:0] sum;
        logic signed [31:0]   res;
        d   = neg ? -$signed({2'b00, p}) : $signed({2'b00, p});
        sum = (PW+2)'(base) + d;
        if (sum > (PW+2)'(32'sh7FFFFFFF)) begin
            res = 32'sh7FFFFFFF;
        end else if (sum < -(PW+2)'(33'sh080000000)) begin
            res = 32'sh80000000;
        end else begin
            res = 32'(sum);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_side.over) begin
                r1_vx <= i_side.sgx ? -{1'b0, i_qx} : {1'b0, i_qx};
                r1_vy <= i_side.sgy ? -{1'b0, i_qy} : {1'b0, i_qy};
            end else begin
                r1_vx <= i_side.vx;
                r1_vy <= i_side.vy;
            end
            r1_vt   <= i_side.vt;
            r1_sx   <= i_side.sx;
            r1_sy   <= i_side.sy;
            r1_sh   <= i_side.sh;
            r1_over <= i_side.over;

            r2_vx   <= r1_vx;
            r2_vy   <= r1_vy;
            r2_vt   <= r1_vt;
            r2_px   <= n_px[31+LW:FRAC_BITS];
            r2_py   <= n_py[31+LW:FRAC_BITS];
            r2_pt   <= n_pt[31+LW:FRAC_BITS];
            r2_sx   <= r1_sx;
            r2_sy   <= r1_sy;
            r2_sh   <= r1_sh;
            r2_over <= r1_over;

            r3_vx   <= r2_vx;
            r3_vy   <= r2_vy;
            r3_vt   <= r2_vt;
            r3_nx   <= step_sat(r2_sx, r2_vx[31], r2_px);
            r3_ny   <= step_sat(r2_sy, r2_vy[31], r2_py);
            r3_nh   <= step_sat(32'(r2_sh), r2_vt[31], r2_pt);
            r3_over <= r2_over;
        end
    end

    assign o_cmd_vel_x     = r3_vx;
    assign o_cmd_vel_y     = r3_vy;
    assign o_cmd_turn_rate = r3_vt;
    assign o_next_x        = r3_nx;
    assign o_next_y        = r3_ny;
    assign o_next_heading  = r3_nh;
    assign o_speed_limited = r3_over;

endmodule

### src/proportional_velocity_command.sv
// Proportional velocity command, top level. The pipeline has 5 front stages,
// 32 square-root stages (one root bit each), 31 divider stages (one quotient bit each)
// and 3 back stages. Throughput is one item per cycle; the whole pipeline holds
// while a finished item waits at the output. Synchronous active-low reset clears the
// valid bits and loads the register reset values; no clearing pass is needed.
module proportional_velocity_command (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic signed [pvc_pkg::XW-1:0]  i_start_x,
    input  logic signed [pvc_pkg::XW-1:0]  i_start_y,
    input  logic signed [pvc_pkg::HW-1:0]  i_start_heading,
    input  logic signed [pvc_pkg::XW-1:0]  i_goal_x,
    input  logic signed [pvc_pkg::XW-1:0]  i_goal_y,
    input  logic signed [pvc_pkg::HW-1:0]  i_goal_heading,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic signed [31:0]             o_cmd_vel_x,
    output logic signed [31:0]             o_cmd_vel_y,
    output logic signed [31:0]             o_cmd_turn_rate,
    output logic signed [31:0]             o_next_x,
    output logic signed [31:0]             o_next_y,
    output logic signed [31:0]             o_next_heading,
    output logic                           o_speed_limited,
    input  logic                           i_cfg_we,
    input  logic [pvc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                    i_cfg_data
);
    import pvc_pkg::*;

    localparam int SIDE_LEN = SQ_STAGES + DIV_STAGES;

    logic [31:0]    r_trans_gain, r_rot_gain;
    logic [LW-1:0]  r_speed_lim, r_turn_lim, r_time_step;
    logic [LATENCY-1:0] r_vld;
    t_side          r_side [SIDE_LEN];
    logic [DW-1:0]  r_dvx  [SQ_STAGES];
    logic [DW-1:0]  r_dvy  [SQ_STAGES];

    logic           n_en;
    logic [NW-1:0]  n_n;
    logic [DW-1:0]  n_dvx, n_dvy;
    t_side          n_side;
    logic [RTW-1:0] n_root;
    logic [QW-1:0]  n_qx, n_qy;

    // The pipeline advances unless a finished item is held at the output.
    assign n_en    = !r_vld[LATENCY-1] || i_ready;
    assign o_ready = n_en;
    assign o_valid = r_vld[LATENCY-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trans_gain <= RST_TRANS_GAIN;
            r_rot_gain   <= RST_ROT_GAIN;
            r_speed_lim  <= RST_SPEED_LIM;
            r_turn_lim   <= RST_TURN_LIM;
            r_time_step  <= RST_TIME_STEP;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TRANS_GAIN: r_trans_gain <= i_cfg_data;
                CFG_ROT_GAIN:   r_rot_gain   <= i_cfg_data;
                CFG_SPEED_LIM:  r_speed_lim  <= i_cfg_data[LW-1:0];
                CFG_TURN_LIM:   r_turn_lim   <= i_cfg_data[LW-1:0];
                CFG_TIME_STEP:  r_time_step  <= i_cfg_data[LW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (n_en) begin
            r_vld <= {r_vld[LATENCY-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en) begin
            r_side[0] <= n_side;
            for (int j = 1; j < SIDE_LEN; j++) begin
                r_side[j] <= r_side[j-1];
            end
            r_dvx[0] <= n_dvx;
            r_dvy[0] <= n_dvy;
            for (int j = 1; j < SQ_STAGES; j++) begin
                r_dvx[j] <= r_dvx[j-1];
                r_dvy[j] <= r_dvy[j-1];
            end
        end
    end

    pvc_front u_front (
        .i_clk           (i_clk),
        .i_en            (n_en),
        .i_start_x       (i_start_x),
        .i_start_y       (i_start_y),
        .i_start_heading (i_start_heading),
        .i_goal_x        (i_goal_x),
        .i_goal_y        (i_goal_y),
        .i_goal_heading  (i_goal_heading),
        .i_trans_gain    (r_trans_gain),
        .i_rot_gain      (r_rot_gain),
        .i_speed_lim     (r_speed_lim),
        .i_turn_lim      (r_turn_lim),
        .o_n             (n_n),
        .o_dvx           (n_dvx),
        .o_dvy           (n_dvy),
        .o_side          (n_side)
    );

    pvc_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_n    (n_n),
        .o_root (n_root)
    );

    pvc_div u_div_x (
        .i_clk      (i_clk),
        .i_en       (n_en),
        .i_dividend (r_dvx[SQ_STAGES-1]),
        .i_divisor  (n_root),
        .o_quot     (n_qx)
    );

    pvc_div u_div_y (
        .i_clk      (i_clk),
        .i_en       (n_en),
        .i_dividend (r_dvy[SQ_STAGES-1]),
        .i_divisor  (n_root),
        .o_quot     (n_qy)
    );

    pvc_back u_back (
        .i_clk           (i_clk),
        .i_en            (n_en),
        .i_side          (r_side[SIDE_LEN-1]),
        .i_qx            (n_qx),
        .i_qy            (n_qy),
        .i_time_step     (r_time_step),
        .o_cmd_vel_x     (o_cmd_vel_x),
        .o_cmd_vel_y     (o_cmd_vel_y),
        .o_cmd_turn_rate (o_cmd_turn_rate),
        .o_next_x        (o_next_x),
        .o_next_y        (o_next_y),
        .o_next_heading  (o_next_heading),
        .o_speed_limited (o_speed_limited)
    );

endmodule
